// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker swpe_checker.sv.
// Depends on nothing; callers supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swpe_pkg.sv =====
// Shared types and constants for the positional-edit stack.
// No dependencies; imported by every module of the block.
package swpe_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // compare width: wide enough for the count and for the 8-bit position
  localparam int CW       = (CNT_W > 8) ? CNT_W : 8;
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_INSERT = 2'd2,
    FN_DELETE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GRP,
    S_FIN
  } state_t;

  // broadcast to every cell on the cycle a beat is taken
  typedef struct packed {
    logic             load;
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] slot;
    word_t            word;
  } cell_cmd_t;

endpackage

// ===== rtl/stack_with_positional_edit.sv =====
// Positional-edit stack: a row of cells, each holding one entry.
// An accepted input beat passes states S_GRP and S_FIN before out_valid is set;
// in_stall holds off the next command until S_FIN ends, while the two-level gather tree
// pulls the removed word out of the cells; the next command is taken
// while a finished result still waits on out_stall.
// Reset clears the fill count and control state; cell contents stay unknown.
module stack_with_positional_edit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic signed [31:0]  in_value,
  input  logic [7:0]          in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_value,
  output logic [7:0]          out_depth,
  output logic [1:0]          out_status
);
  import swpe_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [7:0]       res_depth_r, res_depth_nxt;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_value_r, out_value_nxt;
  logic [7:0]       out_depth_r, out_depth_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             accept, out_load;
  func_t            func;
  logic             is_add, full, empty;
  logic [CW-1:0]    fill_w, pos_slot, slot_ins, slot_del;
  cell_cmd_t        cmd;
  word_t            cell_data [CAPACITY];
  word_t            cell_tap  [CAPACITY];
  word_t            gathered;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign func     = func_t'(in_func);
  assign is_add   = (func == FN_PUSH) || (func == FN_INSERT);
  assign full     = (fill_r == CNT_W'(CAPACITY));
  assign empty    = (fill_r == '0);
  assign fill_w   = CW'(fill_r);
  // position 0 acts as the bottom slot
  assign pos_slot = (in_position == 8'd0) ? '0 : CW'(in_position) - CW'(1);
  assign slot_ins = ((func == FN_PUSH) || (pos_slot > fill_w)) ? fill_w : pos_slot;
  assign slot_del = ((func == FN_POP) || (pos_slot >= fill_w)) ? fill_w - CW'(1)
                                                                : pos_slot;

  always_comb begin
    cmd.load = accept;
    cmd.ins  = accept && is_add && !full;
    cmd.del  = accept && !is_add && !empty;
    cmd.slot = is_add ? slot_ins[IDX_W-1:0] : slot_del[IDX_W-1:0];
    cmd.word = in_value;
  end

  always_comb begin
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    if (cmd.ins) fill_nxt = fill_r + CNT_W'(1);
    else if (cmd.del) fill_nxt = fill_r - CNT_W'(1);
    if (accept) begin
      if (is_add && full)        res_status_nxt = ST_FULL;
      else if (!is_add && empty) res_status_nxt = ST_EMPTY;
      else                       res_status_nxt = ST_OK;
    end
    // depth field carries the low 8 bits of the count
    res_depth_nxt = accept ? 8'(fill_nxt) : res_depth_r;
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      word_t below, above;
      if (i == 0) begin : g_bot
        assign below = cell_data[i];
      end else begin : g_mid_lo
        assign below = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_top
        assign above = cell_data[i];
      end else begin : g_mid_hi
        assign above = cell_data[i+1];
      end
      swpe_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(i)),
        .cmd      (cmd),
        .below    (below),
        .above    (above),
        .data     (cell_data[i]),
        .tap      (cell_tap[i])
      );
    end
  endgenerate

  swpe_gather u_gather (
    .clk      (clk),
    .taps     (cell_tap),
    .gathered (gathered)
  );

  always_comb begin
    state_nxt      = state_r;
    out_load       = 1'b0;
    out_value_nxt  = out_value_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_GRP;
      end
      S_GRP: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load       = 1'b1;
          out_value_nxt  = gathered;
          out_depth_nxt  = res_depth_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_depth_r  <= res_depth_nxt;
    out_value_r  <= out_value_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_depth  = out_depth_r;
  assign out_status = out_status_r;

endmodule

// ===== rtl/swpe_cell.sv =====
// One stack slot: holds a word, shifts from its neighbors on insert/delete.
// Depends on swpe_pkg.
module swpe_cell (
  input  logic                      clk,
  input  logic [swpe_pkg::IDX_W-1:0] cell_idx,
  input  swpe_pkg::cell_cmd_t        cmd,
  input  swpe_pkg::word_t            below,
  input  swpe_pkg::word_t            above,
  output swpe_pkg::word_t            data,
  output swpe_pkg::word_t            tap
);
  import swpe_pkg::*;

  word_t data_r, data_nxt;
  word_t tap_r, tap_nxt;
  logic  at_slot, past_slot;

  assign at_slot   = (cell_idx == cmd.slot);
  assign past_slot = (cell_idx > cmd.slot);

  always_comb begin
    data_nxt = data_r;
    tap_nxt  = tap_r;
    if (cmd.load) begin
      tap_nxt = (cmd.del && at_slot) ? data_r : '0;
      if (cmd.ins) begin
        if (past_slot)    data_nxt = below;
        else if (at_slot) data_nxt = cmd.word;
      end else if (cmd.del) begin
        if (past_slot || at_slot) data_nxt = above;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data = data_r;
  assign tap  = tap_r;

endmodule

// ===== rtl/swpe_gather.sv =====
// Two-level OR tree collecting the word removed by a delete from the cell taps.
// Depends on swpe_pkg. At most one tap is nonzero at a time.
module swpe_gather (
  input  logic            clk,
  input  swpe_pkg::word_t taps [swpe_pkg::CAPACITY],
  output swpe_pkg::word_t gathered
);
  import swpe_pkg::*;

  word_t grp_r   [NGRP];
  word_t grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) grp_nxt[g] = grp_nxt[g] | taps[g * GRP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  always_comb begin
    gathered = '0;
    for (int g = 0; g < NGRP; g++) gathered = gathered | grp_r[g];
  end

endmodule

// ===== rtl/swpe_checker.sv =====
// Port-level checks for the positional-edit stack, bound to the top level.
// Depends on swpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_value,
  input logic [7:0]         out_depth,
  input logic [1:0]         out_status
);
  import swpe_pkg::*;

  // a result beat held back must stay put
  `SWPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value), "held result beat changed")
  // one command in flight: the beat after an accept is always stalled
  `SWPE_ASSERT_NEXT(a_one_inflight, in_valid && !in_stall, in_stall, "second command taken while busy")
  // rejected commands return no word
  `SWPE_ASSERT_NOW(a_reject_zero, out_valid && (out_status != ST_OK), out_value == 32'sd0, "rejected command returned a word")
  // an empty rejection reports an empty stack
  `SWPE_ASSERT_NOW(a_empty_depth, out_valid && (out_status == ST_EMPTY), out_depth == 8'd0, "empty rejection with nonzero depth")
  // a full rejection reports a full stack
  `SWPE_ASSERT_NOW(a_full_depth, out_valid && (out_status == ST_FULL), out_depth == 8'(CAPACITY), "full rejection with wrong depth")

endmodule

bind stack_with_positional_edit swpe_checker u_swpe_checker (.*);

// ===== bench/stack_edit_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of the positional-edit stack, keeps its own copy
// of the stack contents and checks each result beat. Needs swpe_pkg.
module stack_edit_checker
  import swpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_value,
  input  logic [7:0]         out_depth,
  input  logic [1:0]         out_status,
  output int                 pending,
  output int                 errors
);

  typedef struct packed {
    word_t      value;
    logic [7:0] depth;
    status_t    status;
  } stack_result_t;

  // index 0 is the bottom of the stack
  word_t         stack_words[$];
  stack_result_t expected_results[$];

  function automatic stack_result_t apply_stack_cmd(logic [1:0] fn, word_t word,
                                                    logic [7:0] pos);
    stack_result_t r;
    int            slot;
    r.value  = '0;
    r.status = ST_OK;
    slot = (pos == 8'd0) ? 0 : int'(pos) - 1;
    case (func_t'(fn))
      FN_PUSH, FN_INSERT: begin
        if (stack_words.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (fn == FN_PUSH || slot > stack_words.size()) slot = stack_words.size();
          if (slot == stack_words.size()) stack_words.push_back(word);
          else stack_words.insert(slot, word);
        end
      end
      default: begin
        if (stack_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (fn == FN_POP || slot >= stack_words.size()) slot = stack_words.size() - 1;
          r.value = stack_words[slot];
          stack_words.delete(slot);
        end
      end
    endcase
    r.depth = 8'(stack_words.size());
    return r;
  endfunction

  always @(posedge clk) begin
    stack_result_t want;
    stack_result_t got;
    if (!rst_n) begin
      stack_words.delete();
      expected_results.delete();
      pending <= 0;
      errors  <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_stack_cmd(in_func, in_value, in_position));
      if (out_valid && !out_stall) begin
        got.value  = out_value;
        got.depth  = out_depth;
        got.status = status_t'(out_status);
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: value %0d depth %0d status %0d",
                   $time, got.value, got.depth, got.status);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected value %0d depth %0d status %0d, got value %0d depth %0d status %0d",
                     $time, want.value, want.depth, want.status,
                     got.value, got.depth, got.status);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ===== bench/stack_with_positional_edit_test.sv =====
`timescale 1ns / 1ps
// Top of the positional-edit stack bench: clock, reset, command stimulus,
// flow control and verdict. Needs swpe_pkg, the block and stack_edit_checker.
module stack_with_positional_edit_test;
  import swpe_pkg::*;

  localparam int    RAND_CMDS   = 1100;
  localparam int    CYCLE_LIMIT = 200000;
  localparam word_t WORD_MAX    = 32'sh7fffffff;
  localparam word_t WORD_MIN    = 32'sh80000000;

  typedef enum int {SEG_FILL, SEG_MIXED, SEG_DRAIN} seg_kind_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func     = FN_PUSH;
  logic signed [31:0] in_value    = '0;
  logic [7:0]         in_position = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] out_value;
  logic [7:0]         out_depth;
  logic [1:0]         out_status;

  int          pending;
  int          errors;
  int          tx_idle_pct  = 18;
  int          rx_idle_pct  = 84;
  int unsigned approx_depth = 0;
  int          cycle_count;
  logic        in_took      = 1'b0;

  stack_with_positional_edit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .out_depth(out_depth), .out_status(out_status)
  );

  stack_edit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .out_depth(out_depth), .out_status(out_status),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // acceptance as seen at the rising edge, read back at the falling edge
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_cmd(func_t fn, word_t word, logic [7:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_value    <= word;
    in_position <= pos;
    do @(negedge clk); while (!in_took);
    if (fn == FN_PUSH || fn == FN_INSERT) begin
      if (approx_depth < CAPACITY) approx_depth++;
    end else if (approx_depth > 0) begin
      approx_depth--;
    end
  endtask

  // hold off the sender until every outstanding beat has come back
  task automatic await_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int        seg_left;
    int        seg_idx;
    seg_kind_t kind;
    int        roll;
    bit        grow;
    func_t     fn;
    word_t     word;
    logic [7:0] pos;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty stack, extremes, zero and past-top positions, middle edits
    send_cmd(FN_POP,    '0, 8'd0);
    send_cmd(FN_DELETE, '0, 8'd255);
    send_cmd(FN_PUSH,   WORD_MAX, 8'd255);
    send_cmd(FN_PUSH,   WORD_MIN, 8'd0);
    send_cmd(FN_INSERT, -32'sd1, 8'd0);
    send_cmd(FN_INSERT, '0, 8'd1);
    send_cmd(FN_INSERT, 32'sh5a5a5a5a, 8'd255);
    send_cmd(FN_INSERT, 32'sh12345678, 8'd3);
    send_cmd(FN_INSERT, 32'sh0f0f0f0f, 8'd7);
    send_cmd(FN_DELETE, '0, 8'd2);
    send_cmd(FN_DELETE, '0, 8'd255);
    send_cmd(FN_DELETE, '0, 8'd0);
    send_cmd(FN_DELETE, '0, 8'd4);
    send_cmd(FN_POP,    -32'sd1, 8'haa);
    send_cmd(FN_INSERT, 32'sd1, 8'd128);
    repeat (5) send_cmd(FN_POP, '0, 8'h55);
    send_cmd(FN_DELETE, WORD_MAX, 8'd1);
    await_idle();

    // random part: alternating fill, mixed and drain runs so that both
    // the full and the empty stack are hit repeatedly
    seg_left = 0;
    seg_idx  = -1;
    kind     = SEG_FILL;
    for (int i = 0; i < RAND_CMDS; i++) begin
      if (i == RAND_CMDS / 3) begin
        tx_idle_pct = 84;
        rx_idle_pct = 18;
        await_idle();
      end
      if (i == 2 * RAND_CMDS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        await_idle();
      end
      if (seg_left == 0) begin
        seg_idx++;
        seg_left = $urandom_range(100, 180);
        case (seg_idx % 4)
          0:       kind = SEG_FILL;
          2:       kind = SEG_DRAIN;
          default: kind = SEG_MIXED;
        endcase
      end
      seg_left--;

      roll = $urandom_range(99);
      case (kind)
        SEG_FILL:  grow = (roll < 85);
        SEG_DRAIN: grow = (roll < 15);
        default:   grow = (roll < 50);
      endcase
      if (grow) fn = $urandom_range(1) ? FN_PUSH : FN_INSERT;
      else      fn = $urandom_range(1) ? FN_POP : FN_DELETE;

      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       word = WORD_MAX;
          1:       word = WORD_MIN;
          2:       word = '0;
          default: word = -32'sd1;
        endcase
      end else begin
        word = word_t'($urandom);
      end

      if ($urandom_range(9) < 7) pos = 8'($urandom_range(0, approx_depth + 1));
      else                       pos = 8'($urandom_range(0, 255));

      send_cmd(fn, word, pos);
    end

    await_idle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("stack_with_positional_edit test passed");
    end else begin
      $display("stack_with_positional_edit test failed");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stack_with_positional_edit test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swpe_pkg.sv
rtl/swpe_cell.sv
rtl/swpe_gather.sv
rtl/stack_with_positional_edit.sv
rtl/swpe_checker.sv
bench/stack_edit_checker.sv
bench/stack_with_positional_edit_test.sv
